@@ rtl/nts_pkg.sv @@
// Shared constants, codes and word types of the nearest texel sampler.
package nts_pkg;

    localparam int STORE_BYTES = 262144;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int SUM_W       = 30;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_STRIDE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPONENTS = 2'd3;

    localparam logic [12:0] TEX_WIDTH_RESET  = 13'd256;
    localparam logic [12:0] TEX_HEIGHT_RESET = 13'd256;
    localparam logic [14:0] ROW_STRIDE_RESET = 15'd1024;
    localparam logic [2:0]  COMPONENTS_RESET = 3'd4;

    typedef struct packed {
        logic               command;
        logic [17:0]        byte_addr;
        logic [7:0]         byte_value;
        logic signed [31:0] u_coord;
        logic signed [31:0] v_coord;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       address_fault;
    } out_word_t;

    typedef struct packed {
        logic [12:0] tex_width;
        logic [12:0] tex_height;
        logic [14:0] row_stride;
        logic [2:0]  components;
    } cfg_t;

    typedef struct packed {
        logic              is_write;
        logic              fault;
        logic              grey;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
    } task_t;

endpackage

@@ rtl/nts_ram.sv @@
// Generic single-port RAM with registered read data.
module nts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/nts_front.sv @@
// Front pipeline: accepts words, computes texel indices, byte address and fault.
module nts_front import nts_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    output logic     q_push,
    output task_t    q_task,
    input  logic     q_full
);

    typedef struct packed {
        logic        command;
        logic [17:0] byte_addr;
        logic [7:0]  byte_value;
        logic [12:0] x;
        logic [12:0] y;
    } idx_stage_t;

    typedef struct packed {
        logic        command;
        logic [17:0] byte_addr;
        logic [7:0]  byte_value;
        logic [27:0] row_prod;
        logic [15:0] col_prod;
        logic        grey;
    } prod_stage_t;

    function automatic logic [12:0] texel_index(input logic [31:0] raw,
                                                input logic [12:0] size);
        logic [12:0] n;
        logic [29:0] scaled;
        logic [13:0] idx;
        logic [13:0] top;
        n      = (size == 13'd0) ? 13'd1 : size;
        scaled = {14'd0, raw[15:0]} * {17'd0, n} + 30'h8000;
        idx    = scaled[29:16];
        top    = {1'b0, n - 13'd1};
        if (idx > top) begin
            idx = top;
        end
        if (raw[31]) begin
            idx = '0;
        end
        return idx[12:0];
    endfunction

    logic        en;
    logic        st1_valid_reg, st2_valid_reg, st3_valid_reg;
    in_word_t    st1_reg;
    idx_stage_t  st2_reg, st2_next;
    prod_stage_t st3_reg, st3_next;
    logic [SUM_W-1:0] addr_sum;
    logic [SUM_W-1:0] addr_last;

    assign en      = !st3_valid_reg || !q_full;
    assign s_ready = en;

    always_comb begin
        st2_next.command    = st1_reg.command;
        st2_next.byte_addr  = st1_reg.byte_addr;
        st2_next.byte_value = st1_reg.byte_value;
        st2_next.x          = texel_index(st1_reg.u_coord, cfg.tex_width);
        st2_next.y          = texel_index(st1_reg.v_coord, cfg.tex_height);
    end

    always_comb begin
        st3_next.command    = st2_reg.command;
        st3_next.byte_addr  = st2_reg.byte_addr;
        st3_next.byte_value = st2_reg.byte_value;
        st3_next.row_prod   = {13'd0, cfg.row_stride} * {15'd0, st2_reg.y};
        st3_next.col_prod   = {3'd0, st2_reg.x} * {13'd0, cfg.components};
        st3_next.grey       = cfg.components < 3'd3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end else if (en) begin
            st1_valid_reg <= s_valid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg <= s_data;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
        end
    end

    assign addr_sum  = SUM_W'(st3_reg.row_prod) + SUM_W'(st3_reg.col_prod);
    assign addr_last = addr_sum + (st3_reg.grey ? SUM_W'(0) : SUM_W'(2));

    always_comb begin
        q_task.value = st3_reg.byte_value;
        q_task.grey  = st3_reg.grey;
        if (st3_reg.command == CMD_WRITE) begin
            q_task.is_write = 1'b1;
            q_task.fault    = SUM_W'(st3_reg.byte_addr) >= SUM_W'(STORE_BYTES);
            q_task.addr     = ADDR_W'(st3_reg.byte_addr);
        end else begin
            q_task.is_write = 1'b0;
            q_task.fault    = addr_last >= SUM_W'(STORE_BYTES);
            q_task.addr     = addr_sum[ADDR_W-1:0];
        end
    end

    assign q_push = st3_valid_reg && !q_full;

endmodule

@@ rtl/nts_queue.sv @@
// Short FIFO of decoded tasks between the front and back parts.
module nts_queue import nts_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  task_t push_task,
    output logic  full,
    output logic  head_valid,
    output task_t head_task,
    input  logic  pop
);

    task_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_task  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

@@ rtl/nts_back.sv @@
// Back part: executes store writes and texel reads, holds the result register.
module nts_back import nts_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  task_t     q_task,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD1  = 3'd1;
    localparam logic [2:0] ST_RD2  = 3'd2;
    localparam logic [2:0] ST_RD3  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              grey_reg, grey_next;
    logic [7:0]        red_reg, red_next;
    logic [7:0]        green_reg, green_next;
    logic [7:0]        blue_reg, blue_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    logic              out_free;
    logic              mem_en, mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_rdata;

    nts_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (q_task.value),
        .rdata (mem_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        grey_next    = grey_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        mem_en       = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = addr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_task.is_write) begin
                        q_pop    = 1'b1;
                        mem_en   = !q_task.fault;
                        mem_we   = 1'b1;
                        mem_addr = q_task.addr;
                    end else if (q_task.fault) begin
                        if (out_free) begin
                            q_pop        = 1'b1;
                            m_valid_next = 1'b1;
                            m_data_next  = '{red: 8'd0, green: 8'd0, blue: 8'd0,
                                             address_fault: 1'b1};
                        end
                    end else begin
                        q_pop      = 1'b1;
                        mem_en     = 1'b1;
                        mem_addr   = q_task.addr;
                        addr_next  = q_task.addr + 1'b1;
                        grey_next  = q_task.grey;
                        state_next = ST_RD1;
                    end
                end
            end
            ST_RD1: begin
                red_next = mem_rdata;
                if (grey_reg) begin
                    green_next = mem_rdata;
                    blue_next  = mem_rdata;
                    state_next = ST_OUT;
                end else begin
                    mem_en     = 1'b1;
                    addr_next  = addr_reg + 1'b1;
                    state_next = ST_RD2;
                end
            end
            ST_RD2: begin
                green_next = mem_rdata;
                mem_en     = 1'b1;
                state_next = ST_RD3;
            end
            ST_RD3: begin
                blue_next  = mem_rdata;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{red: red_reg, green: green_reg, blue: blue_reg,
                                     address_fault: 1'b0};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        grey_reg   <= grey_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/nearest_texel_sampler.sv @@
// Top level of the nearest texel sampler: configuration, front, queue and back.
//
// Input words on s_valid/s_ready/s_data either write one byte into the texel
// store (command 0) or sample the texture at a Q15.16 u,v (command 1). Each
// sample yields one word on m_valid/m_ready/m_data; writes yield nothing.
// Configuration registers take one write per cycle on cfg_wr_en/cfg_wr_index/
// cfg_wr_data, only while idle: a rule for the user, not enforced by the block.
//
// A word passes a three-stage front pipeline (input, indices, products, with
// the address and bounds check behind the last) into a four-entry task queue.
// The back part runs one task at a time against the single-port store: a write
// or an out-of-range sample is handled in the idle state, a grey sample reads
// one byte and an RGB sample reads three, since the three bytes of a texel come
// through the one read port in turn. The front accepts a word per cycle until
// the queue fills. If the receiver stalls, the result register holds its word,
// the back part waits and the queue and front back up behind it.
// Reset clears the pipeline, queue and result valid and restores the register
// defaults; the texel store is undefined until written.
module nearest_texel_sampler import nts_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data
);

    cfg_t  cfg_reg;
    logic  q_push, q_full, q_valid, q_pop;
    task_t push_task, head_task;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tex_width  <= TEX_WIDTH_RESET;
            cfg_reg.tex_height <= TEX_HEIGHT_RESET;
            cfg_reg.row_stride <= ROW_STRIDE_RESET;
            cfg_reg.components <= COMPONENTS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_TEX_WIDTH:  cfg_reg.tex_width  <= cfg_wr_data[12:0];
                CFG_TEX_HEIGHT: cfg_reg.tex_height <= cfg_wr_data[12:0];
                CFG_ROW_STRIDE: cfg_reg.row_stride <= cfg_wr_data[14:0];
                CFG_COMPONENTS: cfg_reg.components <= cfg_wr_data[2:0];
                default: begin
                end
            endcase
        end
    end

    nts_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_task  (push_task),
        .q_full  (q_full)
    );

    nts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_task  (push_task),
        .full       (q_full),
        .head_valid (q_valid),
        .head_task  (head_task),
        .pop        (q_pop)
    );

    nts_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_task  (head_task),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("task popped from empty queue");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_full)
        else $error("front stalled with room in the queue");

    a_fault_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.address_fault) |->
            (m_data.red == 8'd0 && m_data.green == 8'd0 && m_data.blue == 8'd0))
        else $error("faulted word carries texel data");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && head_task.is_write && m_valid && !m_ready) |=> m_valid)
        else $error("write task disturbed the result register");
`endif

endmodule
